// ===== rtl/core/wpt_pkg.sv =====
// ----------------------------------------------------------------------------
// wpt_pkg: shared types for the word and punctuation tokenizer
// Result kinds, the push control between the scanner and the result queue,
// and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package wpt_pkg;

    // Width of a source character and of the saturating word length.
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 16;

    // Kind of a result item.
    typedef enum logic [1:0] {
        KIND_WORDCH  = 2'd0,
        KIND_WORDEND = 2'd1,
        KIND_PUNCT   = 2'd2
    } kind_t;

    // Push control from the scanner to the result queue.
    // push1 is only ever set together with push0.
    typedef struct packed {
        logic push0;
        logic push1;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/wpt_in_if.sv =====
// ----------------------------------------------------------------------------
// wpt_in_if: character input channel
// Valid/ready channel carrying one source character with its position and
// the end-of-input marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpt_in_if #(
    parameter int POS_WIDTH = 16
);
    logic                       valid;
    logic                       ready;
    logic [wpt_pkg::CHAR_W-1:0] ch;
    logic [POS_WIDTH-1:0]       line_no;
    logic [POS_WIDTH-1:0]       col_no;
    logic                       end_of_input;

    modport source (
        output valid, ch, line_no, col_no, end_of_input,
        input  ready
    );

    modport sink (
        input  valid, ch, line_no, col_no, end_of_input,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/wpt_out_if.sv =====
// ----------------------------------------------------------------------------
// wpt_out_if: token output channel
// Valid/ready channel carrying one result item of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpt_out_if #(
    parameter int POS_WIDTH = 16
);
    logic                       valid;
    logic                       ready;
    wpt_pkg::kind_t             kind;
    logic [wpt_pkg::CHAR_W-1:0] char_out;
    logic [POS_WIDTH-1:0]       start_line;
    logic [POS_WIDTH-1:0]       start_col;
    logic                       first_of_word;
    logic [wpt_pkg::LEN_W-1:0]  word_len;
    logic                       last;

    modport source (
        output valid, kind, char_out, start_line, start_col, first_of_word,
               word_len, last,
        input  ready
    );

    modport sink (
        input  valid, kind, char_out, start_line, start_col, first_of_word,
               word_len, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/wpt_scan.sv =====
// ----------------------------------------------------------------------------
// wpt_scan: character classifier and word state
// Classifies each accepted character, keeps the open-word state, and forms
// the result items, at most two, that the character causes.
// ----------------------------------------------------------------------------
`default_nettype none

module wpt_scan #(
    parameter int POS_WIDTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    wpt_in_if.sink               src,
    input  wire logic            space_ok,
    output wpt_pkg::push_t       push,
    output logic [2+wpt_pkg::CHAR_W+2*POS_WIDTH+1+wpt_pkg::LEN_W+1-1:0] res0,
    output logic [2+wpt_pkg::CHAR_W+2*POS_WIDTH+1+wpt_pkg::LEN_W+1-1:0] res1
);

    typedef struct packed {
        wpt_pkg::kind_t             kind;
        logic [wpt_pkg::CHAR_W-1:0] char_out;
        logic [POS_WIDTH-1:0]       start_line;
        logic [POS_WIDTH-1:0]       start_col;
        logic                       first_of_word;
        logic [wpt_pkg::LEN_W-1:0]  word_len;
        logic                       last;
    } result_t;

    localparam logic [wpt_pkg::LEN_W-1:0]  LEN_MAX  = '1;
    localparam logic [wpt_pkg::LEN_W-1:0]  LEN_ONE  = wpt_pkg::LEN_W'(1);
    localparam logic [POS_WIDTH-1:0]       POS_ONE  = POS_WIDTH'(1);
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_BELL  = 8'h07;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_RBRK  = 8'h5D;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_QUES  = 8'h3F;
    localparam logic [wpt_pkg::CHAR_W-1:0] CH_EXCL  = 8'h21;

    // Word state.
    logic                      in_word_reg;
    logic                      in_word_next;
    logic [wpt_pkg::LEN_W-1:0] word_length_reg;
    logic [wpt_pkg::LEN_W-1:0] word_length_next;
    logic [POS_WIDTH-1:0]      word_start_line_reg;
    logic [POS_WIDTH-1:0]      word_start_line_next;
    logic [POS_WIDTH-1:0]      word_start_col_reg;
    logic [POS_WIDTH-1:0]      word_start_col_next;

    logic    accept;
    logic    is_white;
    logic    is_punct;
    result_t word_end;
    result_t r0;
    result_t r1;

    assign src.ready = space_ok;
    assign accept    = src.valid & space_ok;

    // Character classes: whitespace is tab through carriage return and space.
    assign is_white = (src.ch == CH_SPACE) || ((src.ch >= CH_TAB) && (src.ch <= CH_CR));
    assign is_punct = (src.ch == CH_DOT)   || (src.ch == CH_COMMA) ||
                      (src.ch == CH_COLON) || (src.ch == CH_LBRK)  ||
                      (src.ch == CH_RBRK)  || (src.ch == CH_QUES)  ||
                      (src.ch == CH_EXCL)  || (src.ch == CH_BELL)  ||
                      (src.ch == CH_BS);

    // Word-end item for the word that is open now.
    always_comb
    begin
        word_end               = '0;
        word_end.kind          = wpt_pkg::KIND_WORDEND;
        word_end.start_line    = word_start_line_reg;
        word_end.start_col     = word_start_col_reg;
        word_end.word_len      = word_length_reg;
    end

    // Result items and the next word state.
    always_comb
    begin
        r0                   = '0;
        r1                   = '0;
        push                 = '0;
        in_word_next         = in_word_reg;
        word_length_next     = word_length_reg;
        word_start_line_next = word_start_line_reg;
        word_start_col_next  = word_start_col_reg;

        if (src.end_of_input || is_white)
        begin
            // A separator closes an open word and emits nothing of its own.
            if (in_word_reg)
            begin
                r0               = word_end;
                r0.last          = 1'b1;
                push.push0       = 1'b1;
                in_word_next     = 1'b0;
                word_length_next = '0;
            end
        end
        else if (is_punct)
        begin
            // The mark goes out after the word end, if a word was open.
            r1            = '0;
            r1.kind       = wpt_pkg::KIND_PUNCT;
            r1.char_out   = src.ch;
            r1.start_line = src.line_no;
            r1.start_col  = src.col_no;
            r1.last       = 1'b1;
            push.push0    = 1'b1;
            if (in_word_reg)
            begin
                r0               = word_end;
                push.push1       = 1'b1;
                in_word_next     = 1'b0;
                word_length_next = '0;
            end
            else
            begin
                r0 = r1;
            end
        end
        else if (!in_word_reg)
        begin
            // First character of a new word.
            in_word_next         = 1'b1;
            word_length_next     = LEN_ONE;
            word_start_line_next = src.line_no;
            word_start_col_next  = src.col_no;
            r0.kind              = wpt_pkg::KIND_WORDCH;
            r0.char_out          = src.ch;
            r0.start_line        = src.line_no;
            r0.start_col         = src.col_no;
            r0.first_of_word     = 1'b1;
            r0.last              = 1'b1;
            push.push0           = 1'b1;
        end
        else
        begin
            // Further character of the open word; the length saturates.
            if (word_length_reg != LEN_MAX)
            begin
                word_length_next = word_length_reg + LEN_ONE;
            end
            r0.kind       = wpt_pkg::KIND_WORDCH;
            r0.char_out   = src.ch;
            r0.start_line = word_start_line_reg;
            r0.start_col  = word_start_col_reg;
            r0.last       = 1'b1;
            push.push0    = 1'b1;
        end

        if (!accept)
        begin
            push                 = '0;
            in_word_next         = in_word_reg;
            word_length_next     = word_length_reg;
            word_start_line_next = word_start_line_reg;
            word_start_col_next  = word_start_col_reg;
        end
    end

    assign res0 = r0;
    assign res1 = r1;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg         <= 1'b0;
            word_length_reg     <= '0;
            word_start_line_reg <= POS_ONE;
            word_start_col_reg  <= POS_ONE;
        end
        else
        begin
            in_word_reg         <= in_word_next;
            word_length_reg     <= word_length_next;
            word_start_line_reg <= word_start_line_next;
            word_start_col_reg  <= word_start_col_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wpt_rqueue.sv =====
// ----------------------------------------------------------------------------
// wpt_rqueue: result queue
// Four-entry register queue that takes up to two result items per cycle
// and hands them out one per cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wpt_rqueue #(
    parameter int POS_WIDTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wpt_pkg::push_t       push,
    input  wire logic [2+wpt_pkg::CHAR_W+2*POS_WIDTH+1+wpt_pkg::LEN_W+1-1:0] res0,
    input  wire logic [2+wpt_pkg::CHAR_W+2*POS_WIDTH+1+wpt_pkg::LEN_W+1-1:0] res1,
    output logic                 space_ok,
    wpt_out_if.source            dst
);

    typedef struct packed {
        wpt_pkg::kind_t             kind;
        logic [wpt_pkg::CHAR_W-1:0] char_out;
        logic [POS_WIDTH-1:0]       start_line;
        logic [POS_WIDTH-1:0]       start_col;
        logic                       first_of_word;
        logic [wpt_pkg::LEN_W-1:0]  word_len;
        logic                       last;
    } result_t;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_ONE    = PTR_W'(1);
    localparam logic [PTR_W-1:0] PTR_TWO    = PTR_W'(2);
    localparam logic [CNT_W-1:0] CNT_ROOM   = CNT_W'(DEPTH - 2);

    result_t             mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                pop;
    result_t             head;

    // Room for two more items whatever the output side does this cycle.
    assign space_ok = (count_reg <= CNT_ROOM);

    // Output side.
    assign head              = mem[rd_ptr_reg];
    assign dst.valid         = (count_reg != '0);
    assign dst.kind          = head.kind;
    assign dst.char_out      = head.char_out;
    assign dst.start_line    = head.start_line;
    assign dst.start_col     = head.start_col;
    assign dst.first_of_word = head.first_of_word;
    assign dst.word_len      = head.word_len;
    assign dst.last          = head.last;
    assign pop               = dst.valid & dst.ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push.push1)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_TWO;
        end
        else if (push.push0)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_ONE;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_ONE;
        end
        count_next = count_reg + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem[wr_ptr_reg] <= result_t'(res0);
        end
        if (push.push1)
        begin
            mem[wr_ptr_reg + PTR_ONE] <= result_t'(res1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/word_and_punct_tokenizer.sv =====
// Result items are registered in the result queue when their character is accepted and
// leave on tok_out in order. One character is taken per cycle while the queue has room;
// a mark that closes a word yields two items, which leave one by one through the four-entry result queue.
// tok_in.ready is high while the queue holds at most two items.
// Reset (rst_n low, asynchronous) closes any open word, sets the start position
// to line 1, column 1, and empties the result queue.
// ----------------------------------------------------------------------------
// word_and_punct_tokenizer: streaming word and punctuation tokenizer
// Splits a character stream into word characters, word ends and punctuation
// marks, each tagged with its source position.
// ----------------------------------------------------------------------------
`default_nettype none

module word_and_punct_tokenizer #(
    parameter int POS_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    wpt_in_if.sink    tok_in,
    wpt_out_if.source tok_out
);

    localparam int RES_W = 2 + wpt_pkg::CHAR_W + 2 * POS_WIDTH + 1 + wpt_pkg::LEN_W + 1;

    wpt_pkg::push_t   push;
    logic [RES_W-1:0] res0;
    logic [RES_W-1:0] res1;
    logic             space_ok;

    // Classification and word state.
    wpt_scan #(
        .POS_WIDTH (POS_WIDTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .src      (tok_in),
        .space_ok (space_ok),
        .push     (push),
        .res0     (res0),
        .res1     (res1)
    );

    // Result queue, which drives the output channel.
    wpt_rqueue #(
        .POS_WIDTH (POS_WIDTH)
    ) u_rqueue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res0     (res0),
        .res1     (res1),
        .space_ok (space_ok),
        .dst      (tok_out)
    );

    // Input back-pressure only comes from a queue that holds items.
    assert property (@(posedge clk) disable iff (!rst_n)
        !tok_in.ready |-> tok_out.valid)
    else $error("input stalled with an empty result queue");

    // A word end always reports a nonzero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_out.valid && (tok_out.kind == wpt_pkg::KIND_WORDEND) |-> (tok_out.word_len != '0))
    else $error("word end with zero length");

    // Only word ends carry a length.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_out.valid && (tok_out.kind != wpt_pkg::KIND_WORDEND) |-> (tok_out.word_len == '0))
    else $error("length on an item that is not a word end");

    // The first-of-word flag only marks word characters.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_out.valid && tok_out.first_of_word |-> (tok_out.kind == wpt_pkg::KIND_WORDCH))
    else $error("first-of-word flag on an item that is not a word character");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for word_and_punct_tokenizer
// Feeds a character stream through the valid/ready input channel and checks
// every token item against an in-bench tokenizer. A short table covers each
// character class and position extremes, and random text with noise follows
// under back-pressure on both sides.
// ----------------------------------------------------------------------------

module tb;

    // Control and whitespace bytes by name.
    localparam logic [7:0] CH_BELL  = 8'd7;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // A table row with this count takes its tokens from the predictor.
    localparam int PREDICT = -1;

    localparam int RAND_ITEMS  = 520;
    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        wpt_pkg::kind_t kind;
        logic [7:0]     ch;
        logic [15:0]    line;
        logic [15:0]    col;
        logic           first;
        logic [15:0]    len;
        logic           last;
    } token_t;

    typedef struct {
        logic [7:0]  ch;
        logic [15:0] line;
        logic [15:0] col;
        logic        eoi;
        int          n_typed;
        token_t      t0;
        token_t      t1;
    } char_row_t;

    logic clk;
    logic rst_n;

    wpt_in_if  #(.POS_WIDTH(16)) tok_in_ch ();
    wpt_out_if #(.POS_WIDTH(16)) tok_out_ch ();

    word_and_punct_tokenizer #(
        .POS_WIDTH (16)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (tok_in_ch),
        .tok_out (tok_out_ch)
    );

    // Tokenizer state as the block should hold it.
    logic        word_open;
    logic [15:0] word_len_cnt;
    logic [15:0] word_line;
    logic [15:0] word_col;

    token_t      step_tokens [2];
    token_t      pending_tokens [$];
    char_row_t   directed_rows [$];
    int          mismatch_count;

    bit          tx_gaps_on;
    bit          sink_gaps_on;
    bit          hold_req;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    int          sent;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_mark(logic [7:0] c);
        return c == "." || c == "," || c == ":" || c == "[" || c == "]" ||
               c == "?" || c == "!" || c == CH_BELL || c == CH_BS;
    endfunction

    function automatic token_t mk_tok(wpt_pkg::kind_t kind, logic [7:0] c, logic [15:0] ln,
                                      logic [15:0] col, logic first, logic [15:0] len,
                                      logic last);
        token_t t;
        t.kind  = kind;
        t.ch    = c;
        t.line  = ln;
        t.col   = col;
        t.first = first;
        t.len   = len;
        t.last  = last;
        return t;
    endfunction

    function automatic char_row_t mk_row(logic [7:0] c, logic [15:0] ln, logic [15:0] col,
                                         logic eoi, int n_typed = PREDICT,
                                         token_t t0 = '0, token_t t1 = '0);
        char_row_t r;
        r.ch      = c;
        r.line    = ln;
        r.col     = col;
        r.eoi     = eoi;
        r.n_typed = n_typed;
        r.t0      = t0;
        r.t1      = t1;
        return r;
    endfunction

    // Works out the tokens that one character causes and advances the state.
    function automatic int tokenize_char(logic [7:0] c, logic [15:0] ln, logic [15:0] col,
                                         logic eoi);
        int n;
        n = 0;
        if (eoi || is_blank(c) || is_mark(c))
        begin
            if (word_open)
            begin
                step_tokens[n] = mk_tok(wpt_pkg::KIND_WORDEND, 8'd0, word_line, word_col,
                                        1'b0, word_len_cnt, 1'b0);
                n++;
                word_open    = 1'b0;
                word_len_cnt = '0;
            end
            if (!eoi && is_mark(c))
            begin
                step_tokens[n] = mk_tok(wpt_pkg::KIND_PUNCT, c, ln, col, 1'b0, 16'd0, 1'b0);
                n++;
            end
        end
        else if (!word_open)
        begin
            word_open      = 1'b1;
            word_len_cnt   = 16'd1;
            word_line      = ln;
            word_col       = col;
            step_tokens[0] = mk_tok(wpt_pkg::KIND_WORDCH, c, ln, col, 1'b1, 16'd0, 1'b0);
            n = 1;
        end
        else
        begin
            // The length saturates and holds until the word closes.
            if (word_len_cnt != 16'hFFFF)
                word_len_cnt++;
            step_tokens[0] = mk_tok(wpt_pkg::KIND_WORDCH, c, word_line, word_col, 1'b0,
                                    16'd0, 1'b0);
            n = 1;
        end
        if (n > 0)
            step_tokens[n - 1].last = 1'b1;
        return n;
    endfunction

    function automatic logic [7:0] rand_word_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_blank(c) || is_mark(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_mark();
        case ($urandom_range(0, 8))
            0:       return ".";
            1:       return ",";
            2:       return ":";
            3:       return "[";
            4:       return "]";
            5:       return "?";
            6:       return "!";
            7:       return CH_BELL;
            default: return CH_BS;
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 9))
            0:       return CH_TAB;
            1:       return CH_VT;
            2:       return CH_FF;
            3:       return CH_CR;
            4:       return CH_LF;
            default: return CH_SPACE;
        endcase
    endfunction

    // Offers one item, waits for its handshake and records what it should cause.
    task automatic offer(char_row_t r);
        int n;
        if (tx_gaps_on && $urandom_range(0, 4) == 0)
        begin
            tok_in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        tok_in_ch.valid        <= 1'b1;
        tok_in_ch.ch           <= r.ch;
        tok_in_ch.line_no      <= r.line;
        tok_in_ch.col_no       <= r.col;
        tok_in_ch.end_of_input <= r.eoi;
        do
            @(posedge clk);
        while (!tok_in_ch.ready);
        n = tokenize_char(r.ch, r.line, r.col, r.eoi);
        if (r.n_typed == PREDICT)
        begin
            for (int i = 0; i < n; i++)
                pending_tokens.push_back(step_tokens[i]);
        end
        else
        begin
            if (r.n_typed > 0)
                pending_tokens.push_back(r.t0);
            if (r.n_typed > 1)
                pending_tokens.push_back(r.t1);
        end
    endtask

    // Sends a character of running text at the current position.
    task automatic send_at(logic [7:0] c, logic eoi);
        offer(mk_row(c, cur_line, cur_col, eoi));
        cur_col++;
        sent++;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each token item with the oldest expectation.
    always @(posedge clk)
    begin : check_tokens
        token_t want;
        if (rst_n && tok_out_ch.valid && tok_out_ch.ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("token item with none expected: kind %0d char 0x%0h",
                       tok_out_ch.kind, tok_out_ch.char_out);
                mismatch_count++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("kind", 16'(want.kind), 16'(tok_out_ch.kind));
                check_field("char_out", 16'(want.ch), 16'(tok_out_ch.char_out));
                check_field("start_line", want.line, tok_out_ch.start_line);
                check_field("start_col", want.col, tok_out_ch.start_col);
                check_field("first_of_word", 16'(want.first), 16'(tok_out_ch.first_of_word));
                check_field("word_len", want.len, tok_out_ch.word_len);
                check_field("last", 16'(want.last), 16'(tok_out_ch.last));
            end
        end
    end

    // Token receiver: random stall bursts, and one long hold-off on request.
    initial
    begin : token_sink
        int n;
        tok_out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                tok_out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (sink_gaps_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 5);
                tok_out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                tok_out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Reset, stimulus and end of run.
    initial
    begin : stimulus
        int  len;
        bit  held;
        bit  paused;

        rst_n                  <= 1'b0;
        tok_in_ch.valid        <= 1'b0;
        tok_in_ch.ch           <= '0;
        tok_in_ch.line_no      <= 16'd1;
        tok_in_ch.col_no       <= 16'd1;
        tok_in_ch.end_of_input <= 1'b0;
        mismatch_count = 0;
        tx_gaps_on     = 1'b1;
        sink_gaps_on   = 1'b1;
        hold_req       = 1'b0;
        held           = 1'b0;
        paused         = 1'b0;
        word_open      = 1'b0;
        word_len_cnt   = '0;
        word_line      = 16'd1;
        word_col       = 16'd1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Each class of character, a mark inside a word, and position extremes.
        directed_rows.push_back(mk_row("A", 16'd1, 16'd1, 1'b0, 1,
            mk_tok(wpt_pkg::KIND_WORDCH, "A", 16'd1, 16'd1, 1'b1, 16'd0, 1'b1)));
        directed_rows.push_back(mk_row("b", 16'd1, 16'd2, 1'b0));
        directed_rows.push_back(mk_row(CH_SPACE, 16'd1, 16'd3, 1'b0, 1,
            mk_tok(wpt_pkg::KIND_WORDEND, 8'd0, 16'd1, 16'd1, 1'b0, 16'd2, 1'b1)));
        directed_rows.push_back(mk_row(CH_SPACE, 16'd1, 16'd4, 1'b0, 0));
        directed_rows.push_back(mk_row(".", 16'd1, 16'd5, 1'b0, 1,
            mk_tok(wpt_pkg::KIND_PUNCT, ".", 16'd1, 16'd5, 1'b0, 16'd0, 1'b1)));
        directed_rows.push_back(mk_row("x", 16'd1, 16'd6, 1'b0));
        directed_rows.push_back(mk_row(",", 16'd1, 16'd7, 1'b0, 2,
            mk_tok(wpt_pkg::KIND_WORDEND, 8'd0, 16'd1, 16'd6, 1'b0, 16'd1, 1'b0),
            mk_tok(wpt_pkg::KIND_PUNCT, ",", 16'd1, 16'd7, 1'b0, 16'd0, 1'b1)));
        directed_rows.push_back(mk_row(":", 16'd1, 16'd8, 1'b0));
        directed_rows.push_back(mk_row("[", 16'd1, 16'd9, 1'b0));
        directed_rows.push_back(mk_row("]", 16'd1, 16'd10, 1'b0));
        directed_rows.push_back(mk_row("?", 16'd1, 16'd11, 1'b0));
        directed_rows.push_back(mk_row("!", 16'd1, 16'd12, 1'b0));
        directed_rows.push_back(mk_row(CH_BELL, 16'd1, 16'd13, 1'b0));
        directed_rows.push_back(mk_row("w", 16'd1, 16'd14, 1'b0));
        directed_rows.push_back(mk_row(CH_BS, 16'd1, 16'd15, 1'b0));
        directed_rows.push_back(mk_row("y", 16'd1, 16'd16, 1'b0));
        directed_rows.push_back(mk_row(CH_TAB, 16'd1, 16'd17, 1'b0));
        directed_rows.push_back(mk_row("z", 16'd1, 16'd18, 1'b0));
        directed_rows.push_back(mk_row(CH_LF, 16'd1, 16'd19, 1'b0));
        // A word that runs on across a change of line stays open.
        directed_rows.push_back(mk_row("q", 16'd2, 16'hFFFF, 1'b0));
        directed_rows.push_back(mk_row("r", 16'd3, 16'd1, 1'b0));
        directed_rows.push_back(mk_row(CH_VT, 16'd3, 16'd2, 1'b0));
        directed_rows.push_back(mk_row(8'h00, 16'd0, 16'd0, 1'b0, 1,
            mk_tok(wpt_pkg::KIND_WORDCH, 8'h00, 16'd0, 16'd0, 1'b1, 16'd0, 1'b1)));
        directed_rows.push_back(mk_row(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0));
        // End of text closes the word; the mark it carries is ignored.
        directed_rows.push_back(mk_row(".", 16'd1, 16'd1, 1'b1, 1,
            mk_tok(wpt_pkg::KIND_WORDEND, 8'd0, 16'd0, 16'd0, 1'b0, 16'd2, 1'b1)));
        directed_rows.push_back(mk_row(CH_FF, 16'd1, 16'd1, 1'b1, 0));
        directed_rows.push_back(mk_row(CH_CR, 16'd1, 16'd1, 1'b0, 0));

        foreach (directed_rows[i])
            offer(directed_rows[i]);

        // Random text: mostly words with separators, some raw noise.
        tx_gaps_on   = 1'b1;
        sink_gaps_on = 1'b1;
        cur_line     = 16'd1;
        cur_col      = 16'd1;
        sent         = 0;
        while (sent < RAND_ITEMS)
        begin
            if (!held && sent >= 150)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && sent >= 300)
            begin
                // Let the block drain completely before going on.
                paused = 1'b1;
                tok_in_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_tokens.size() != 0);
            end
            if (sent >= RAND_ITEMS - 100)
            begin
                tx_gaps_on   = 1'b0;
                sink_gaps_on = 1'b0;
            end

            if ($urandom_range(0, 99) < 80)
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        cur_line++;
                        cur_col = 16'd1;
                    end
                    send_at(rand_word_byte(), 1'b0);
                end
                case ($urandom_range(0, 19))
                    0:
                    begin
                        send_at(rand_word_byte(), 1'b1);
                        cur_line = 16'd1;
                        cur_col  = 16'd1;
                    end
                    1, 2:
                    begin
                        send_at(CH_LF, 1'b0);
                        cur_line++;
                        cur_col = 16'd1;
                    end
                    3, 4, 5, 6, 7:
                        send_at(rand_mark(), 1'b0);
                    default:
                        send_at(rand_blank(), 1'b0);
                endcase
            end
            else
            begin
                offer(mk_row(8'($urandom), 16'($urandom), 16'($urandom),
                             $urandom_range(0, 7) == 0));
                sent++;
            end
        end

        // Drain and finish.
        tok_in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tokens.size() != 0);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
